// ===== design/jnke_pkg.sv =====
// shared types, constants and key tables for the json nested key extractor
// no dependencies
package jnke_pkg;

   localparam int DEPTH_BITS  = 8;
   localparam int LENGTH_BITS = 16;

   localparam int OUTER_LEN = 5;
   localparam int INNER_LEN = 12;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_L      = 8'h6C;

   typedef enum logic [8:0] {
      PH_OUTER     = 9'b000000001,
      PH_KEY_END   = 9'b000000010,
      PH_KEY_WS    = 9'b000000100,
      PH_COLON_WS  = 9'b000001000,
      PH_INNER     = 9'b000010000,
      PH_INNER_WS1 = 9'b000100000,
      PH_INNER_WS2 = 9'b001000000,
      PH_VALUE     = 9'b010000000,
      PH_FINISHED  = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic                   has_byte;
      logic [7:0]             name_byte;
      logic                   has_done;
      logic                   found;
      logic [LENGTH_BITS-1:0] name_length;
   } result_type;

   function automatic logic is_ws(input logic [7:0] c);
      return c inside {8'h20, 8'h09, 8'h0A, 8'h0D};
   endfunction

   function automatic logic [7:0] outer_key_char(input logic [2:0] pos);
      case (pos)
         3'd0: return CH_QUOTE;
         3'd1: return CH_L;
         3'd2: return CH_L;
         3'd3: return 8'h6D;
         3'd4: return CH_QUOTE;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] inner_key_char(input logic [3:0] pos);
      case (pos)
         4'd0:  return CH_QUOTE;
         4'd1:  return 8'h6D;
         4'd2:  return 8'h6F;
         4'd3:  return 8'h64;
         4'd4:  return 8'h65;
         4'd5:  return CH_L;
         4'd6:  return 8'h5F;
         4'd7:  return 8'h6E;
         4'd8:  return 8'h61;
         4'd9:  return 8'h6D;
         4'd10: return 8'h65;
         4'd11: return CH_QUOTE;
         default: return 8'h00;
      endcase
   endfunction

endpackage

// ===== design/jnke_parser.sv =====
// byte parser: key matchers, brace depth tracking and value extraction
// depends on jnke_pkg
module jnke_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             text_byte,
   input  logic                   final_byte,
   output jnke_pkg::result_type   result
);

   localparam logic [jnke_pkg::DEPTH_BITS-1:0]  DEPTH_MAX  = '1;
   localparam logic [jnke_pkg::LENGTH_BITS-1:0] LENGTH_MAX = '1;

   jnke_pkg::phase_type                phase_ff, phase_in;
   logic [2:0]                         outer_pos_ff, outer_pos_in;
   logic [3:0]                         inner_pos_ff, inner_pos_in;
   logic [jnke_pkg::DEPTH_BITS-1:0]    depth_ff, depth_in;
   logic                               quoted_ff, quoted_in;
   logic                               esc_ff, esc_in;
   logic                               vesc_ff, vesc_in;
   logic [jnke_pkg::LENGTH_BITS-1:0]   count_ff, count_in;

   always_comb begin
      logic [3:0]                      op;
      logic [4:0]                      ip;
      logic [jnke_pkg::DEPTH_BITS-1:0] dec;
      logic                            emit;
      phase_in     = phase_ff;
      outer_pos_in = outer_pos_ff;
      inner_pos_in = inner_pos_ff;
      depth_in     = depth_ff;
      quoted_in    = quoted_ff;
      esc_in       = esc_ff;
      vesc_in      = vesc_ff;
      count_in     = count_ff;
      emit         = 1'b0;
      op           = '0;
      ip           = '0;
      dec          = '0;
      case (phase_ff)
         jnke_pkg::PH_OUTER: begin
            if (text_byte == jnke_pkg::outer_key_char(outer_pos_ff)) begin
               op = {1'b0, outer_pos_ff} + 4'd1;
            end else begin
               op = (text_byte == jnke_pkg::CH_QUOTE) ? 4'd1 : 4'd0;
            end
            if (op == 4'(jnke_pkg::OUTER_LEN)) begin
               outer_pos_in = '0;
               phase_in     = jnke_pkg::PH_KEY_END;
            end else begin
               outer_pos_in = op[2:0];
            end
         end
         jnke_pkg::PH_KEY_END, jnke_pkg::PH_KEY_WS: begin
            if (jnke_pkg::is_ws(text_byte)) begin
               phase_in = jnke_pkg::PH_KEY_WS;
            end else if (text_byte == jnke_pkg::CH_COLON) begin
               phase_in = jnke_pkg::PH_COLON_WS;
            end else begin
               if (phase_ff == jnke_pkg::PH_KEY_END && text_byte == jnke_pkg::CH_L) begin
                  outer_pos_in = 3'd2;
               end else begin
                  outer_pos_in = (text_byte == jnke_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
               end
               phase_in = jnke_pkg::PH_OUTER;
            end
         end
         jnke_pkg::PH_COLON_WS: begin
            if (jnke_pkg::is_ws(text_byte)) begin
               phase_in = jnke_pkg::PH_COLON_WS;
            end else if (text_byte == jnke_pkg::CH_LBRACE) begin
               phase_in     = jnke_pkg::PH_INNER;
               depth_in     = jnke_pkg::DEPTH_BITS'(1);
               quoted_in    = 1'b0;
               esc_in       = 1'b0;
               inner_pos_in = '0;
            end else begin
               outer_pos_in = (text_byte == jnke_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
               phase_in     = jnke_pkg::PH_OUTER;
            end
         end
         jnke_pkg::PH_INNER, jnke_pkg::PH_INNER_WS1,
         jnke_pkg::PH_INNER_WS2, jnke_pkg::PH_VALUE: begin
            if (phase_ff == jnke_pkg::PH_INNER) begin
               if (text_byte == jnke_pkg::inner_key_char(inner_pos_ff)) begin
                  ip = {1'b0, inner_pos_ff} + 5'd1;
               end else begin
                  ip = (text_byte == jnke_pkg::CH_QUOTE) ? 5'd1 : 5'd0;
               end
               if (ip == 5'(jnke_pkg::INNER_LEN)) begin
                  inner_pos_in = '0;
                  phase_in     = jnke_pkg::PH_INNER_WS1;
               end else begin
                  inner_pos_in = ip[3:0];
               end
            end else if (phase_ff == jnke_pkg::PH_INNER_WS1) begin
               if (text_byte == jnke_pkg::CH_COLON) begin
                  phase_in = jnke_pkg::PH_INNER_WS2;
               end else if (!jnke_pkg::is_ws(text_byte)) begin
                  phase_in = jnke_pkg::PH_FINISHED;
               end
            end else if (phase_ff == jnke_pkg::PH_INNER_WS2) begin
               if (text_byte == jnke_pkg::CH_QUOTE) begin
                  phase_in = jnke_pkg::PH_VALUE;
                  vesc_in  = 1'b0;
               end else if (!jnke_pkg::is_ws(text_byte)) begin
                  phase_in = jnke_pkg::PH_FINISHED;
               end
            end else begin
               emit = 1'b1;
               if (vesc_ff) begin
                  vesc_in = 1'b0;
               end else if (text_byte == jnke_pkg::CH_QUOTE) begin
                  emit     = 1'b0;
                  phase_in = jnke_pkg::PH_FINISHED;
               end else if (text_byte == jnke_pkg::CH_BSLASH) begin
                  vesc_in = 1'b1;
               end
               if (emit && count_ff != LENGTH_MAX) begin
                  count_in = count_ff + jnke_pkg::LENGTH_BITS'(1);
               end
            end
            // string- and escape-aware depth tracking
            if (phase_in != jnke_pkg::PH_FINISHED) begin
               if (quoted_ff) begin
                  if (esc_ff) begin
                     esc_in = 1'b0;
                  end else if (text_byte == jnke_pkg::CH_BSLASH) begin
                     esc_in = 1'b1;
                  end else if (text_byte == jnke_pkg::CH_QUOTE) begin
                     quoted_in = 1'b0;
                  end
               end else if (text_byte == jnke_pkg::CH_LBRACE) begin
                  if (depth_ff != DEPTH_MAX) begin
                     depth_in = depth_ff + jnke_pkg::DEPTH_BITS'(1);
                  end
               end else if (text_byte == jnke_pkg::CH_RBRACE) begin
                  dec = (depth_ff != '0) ? depth_ff - jnke_pkg::DEPTH_BITS'(1) : '0;
                  depth_in = dec;
                  if (dec == '0) begin
                     phase_in = jnke_pkg::PH_FINISHED;
                  end
               end else if (text_byte == jnke_pkg::CH_QUOTE) begin
                  quoted_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      result.has_byte    = emit;
      result.name_byte   = text_byte;
      result.has_done    = final_byte;
      result.found       = (count_in != '0);
      result.name_length = count_in;

      if (final_byte) begin
         phase_in     = jnke_pkg::PH_OUTER;
         outer_pos_in = '0;
         inner_pos_in = '0;
         depth_in     = '0;
         quoted_in    = 1'b0;
         esc_in       = 1'b0;
         vesc_in      = 1'b0;
         count_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= jnke_pkg::PH_OUTER;
         outer_pos_ff <= '0;
         inner_pos_ff <= '0;
         depth_ff     <= '0;
         quoted_ff    <= 1'b0;
         esc_ff       <= 1'b0;
         vesc_ff      <= 1'b0;
         count_ff     <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         outer_pos_ff <= outer_pos_in;
         inner_pos_ff <= inner_pos_in;
         depth_ff     <= depth_in;
         quoted_ff    <= quoted_in;
         esc_ff       <= esc_in;
         vesc_ff      <= vesc_in;
         count_ff     <= count_in;
      end
   end

endmodule

// ===== design/json_nested_key_extractor.sv =====
// top level: byte parser followed by a two-entry result queue
// depends on jnke_pkg and jnke_parser
// results: a taken byte's beat is registered into the head entry of the result queue,
// or the spare entry while the head is held; throughput: one byte per cycle while the
// spare entry is empty; a final byte inside the value gives two beats, name byte then done
// reset: synchronous, clears parser state and empties the result queue
module json_nested_key_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_done,
   output logic [7:0]  rsp_name_byte,
   output logic        rsp_found,
   output logic [15:0] rsp_name_length
);

   jnke_pkg::result_type res;
   jnke_pkg::result_type head_ff, head_in, spare_ff, spare_in;
   logic                 head_vld_ff, head_vld_in, spare_vld_ff, spare_vld_in;
   logic                 sub_ff, sub_in;
   logic                 accept, push, beat, pop;

   assign req_stall = spare_vld_ff;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (res.has_byte || res.has_done);

   jnke_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_text_byte),
      .final_byte (req_final_byte),
      .result     (res)
   );

   assign rsp_valid = head_vld_ff;
   assign beat      = rsp_valid && !rsp_stall;
   assign pop       = beat && (!(head_ff.has_byte && head_ff.has_done) || sub_ff);

   assign rsp_is_done     = head_ff.has_done && (!head_ff.has_byte || sub_ff);
   assign rsp_name_byte   = rsp_is_done ? 8'h00 : head_ff.name_byte;
   assign rsp_found       = rsp_is_done ? head_ff.found : 1'b0;
   assign rsp_name_length = rsp_is_done ? 16'(head_ff.name_length) : 16'h0000;

   always_comb begin
      head_in      = head_ff;
      spare_in     = spare_ff;
      head_vld_in  = head_vld_ff;
      spare_vld_in = spare_vld_ff;
      sub_in       = sub_ff;
      if (pop) begin
         sub_in = 1'b0;
         if (spare_vld_ff) begin
            head_in      = spare_ff;
            spare_vld_in = 1'b0;
         end else begin
            head_in     = res;
            head_vld_in = push;
         end
      end else begin
         if (beat) begin
            sub_in = 1'b1;
         end
         if (push) begin
            if (head_vld_ff) begin
               spare_in     = res;
               spare_vld_in = 1'b1;
            end else begin
               head_in     = res;
               head_vld_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff  <= 1'b0;
         spare_vld_ff <= 1'b0;
         sub_ff       <= 1'b0;
      end else begin
         head_vld_ff  <= head_vld_in;
         spare_vld_ff <= spare_vld_in;
         sub_ff       <= sub_in;
      end
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

endmodule
